// ===== rtl/byte_ring_fifo_top_assert.svh =====
// Assertion macros for the byte ring FIFO.
// Used by modules that carry concurrent checks; expects clk and rst in scope.
`ifndef BYTE_RING_FIFO_TOP_ASSERT_SVH
`define BYTE_RING_FIFO_TOP_ASSERT_SVH

// Property must hold at every clock edge outside reset.
`define BRF_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define BRF_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/brf_pkg.sv =====
// Shared types and constants for the byte ring FIFO.
// No dependencies; every RTL module except brf_ram refers to it by scoped names.
`default_nettype none

package brf_pkg;

  // storage geometry
  localparam int DEPTH    = 4096;
  localparam int PTR_W    = $clog2(DEPTH);
  localparam int USIZE_W  = PTR_W + 1;
  localparam int MAX_READ = 64;
  localparam int NREAD_W  = $clog2(MAX_READ + 1);

  // field widths
  localparam int CMD_W  = 3;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 13;
  localparam int CFG_W  = 13;
  localparam int OUT_W  = 12;
  localparam int SZ_W   = (CFG_W > USIZE_W) ? CFG_W : USIZE_W;
  localparam int MIN_W  = (CNT_W > PTR_W) ? CNT_W : PTR_W;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4096);

  // stream packing
  localparam int IN_TDATA_W  = 24;
  localparam int IN_BYTE_LSB = 0;
  localparam int IN_CNT_LSB  = IN_BYTE_LSB + BYTE_W;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_BYTE_LSB = 0;
  localparam int OUT_ACC_BIT  = OUT_BYTE_LSB + BYTE_W;
  localparam int OUT_RD_LSB   = OUT_ACC_BIT + 1;
  localparam int OUT_WR_LSB   = OUT_RD_LSB + OUT_W;
  localparam int OUT_USED_W   = OUT_WR_LSB + OUT_W;

  // APB
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_RING_SIZE = REG_IDX_W'(0);

  // command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // modulo unit
  localparam int STEP_W = $clog2(CNT_W + 1);

  // command codes on the input channel
  localparam logic [CMD_W-1:0] CMD_WRITE    = CMD_W'(0);
  localparam logic [CMD_W-1:0] CMD_READ     = CMD_W'(1);
  localparam logic [CMD_W-1:0] CMD_ADV_HEAD = CMD_W'(2);
  localparam logic [CMD_W-1:0] CMD_ADV_TAIL = CMD_W'(3);
  localparam logic [CMD_W-1:0] CMD_RESET    = CMD_W'(4);

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_ADV_HEAD,
    OP_ADV_TAIL,
    OP_CLEAR,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [BYTE_W-1:0] wbyte;
    logic [CNT_W-1:0]  count;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0]  writeable;
    logic [OUT_W-1:0]  readable;
    logic              accepted;
    logic              last;
    logic              byte_valid;
    logic [BYTE_W-1:0] read_byte;
  } res_t;

  typedef struct packed {
    logic [PTR_W-1:0] base;
    logic [CNT_W-1:0] amount;
  } mod_req_t;

endpackage

`default_nettype wire

// ===== rtl/brf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds while no read is issued. No dependencies.
`default_nettype none

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brf_modu.sv =====
// Bit-serial unit computing (base + amount) mod size for pointer advances.
// One amount bit per cycle, then one add-and-reduce step. Uses brf_pkg.
`default_nettype none

module brf_modu (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  brf_pkg::mod_req_t                req,
  input  logic [brf_pkg::USIZE_W-1:0]      size,
  output logic                             done,
  output logic [brf_pkg::PTR_W-1:0]        result
);

  localparam int PTR_W   = brf_pkg::PTR_W;
  localparam int USIZE_W = brf_pkg::USIZE_W;
  localparam int CNT_W   = brf_pkg::CNT_W;
  localparam int STEP_W  = brf_pkg::STEP_W;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [PTR_W-1:0]  rem;
  logic [CNT_W-1:0]  amt;
  logic [PTR_W-1:0]  base;

  logic [USIZE_W-1:0] trial;
  logic [PTR_W-1:0]   rem_next;
  logic [USIZE_W-1:0] sum;
  logic [PTR_W-1:0]   sum_mod;

  always_comb begin
    // restoring step: shift in the next amount bit, subtract size if it fits
    trial    = {rem, amt[CNT_W-1]};
    rem_next = (trial >= size) ? PTR_W'(trial - size) : PTR_W'(trial);
    sum      = USIZE_W'(base) + USIZE_W'(rem);
    sum_mod  = (sum >= size) ? PTR_W'(sum - size) : PTR_W'(sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        if (step == STEP_W'(CNT_W)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      amt  <= req.amount;
      base <= req.base;
    end else if (busy) begin
      if (step == STEP_W'(CNT_W)) begin
        result <= sum_mod;
      end else begin
        rem <= rem_next;
        amt <= {amt[CNT_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brf_front.sv =====
// Front end: accepts input words, decodes the command and queues the items.
// Two-entry queue toward the back end. Uses brf_pkg.
`default_nettype none

module brf_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [brf_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [brf_pkg::CMD_W-1:0]         s_tuser,
  output logic                              q_valid,
  output brf_pkg::item_t                    q_item,
  input  logic                              q_pop
);

  localparam int QDEPTH = brf_pkg::QDEPTH;
  localparam int QPTR_W = brf_pkg::QPTR_W;
  localparam int QCNT_W = brf_pkg::QCNT_W;

  brf_pkg::item_t    queue [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;

  brf_pkg::item_t in_item;
  logic           push;

  always_comb begin
    in_item.wbyte = s_tdata[brf_pkg::IN_BYTE_LSB +: brf_pkg::BYTE_W];
    in_item.count = s_tdata[brf_pkg::IN_CNT_LSB +: brf_pkg::CNT_W];
    unique case (s_tuser)
      brf_pkg::CMD_WRITE:    in_item.op = brf_pkg::OP_WRITE;
      brf_pkg::CMD_READ:     in_item.op = brf_pkg::OP_READ;
      brf_pkg::CMD_ADV_HEAD: in_item.op = brf_pkg::OP_ADV_HEAD;
      brf_pkg::CMD_ADV_TAIL: in_item.op = brf_pkg::OP_ADV_TAIL;
      brf_pkg::CMD_RESET:    in_item.op = brf_pkg::OP_CLEAR;
      default:               in_item.op = brf_pkg::OP_NOP;
    endcase
  end

  assign s_tready = (fill != QCNT_W'(QDEPTH));
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (fill != '0);
  assign q_item   = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !q_pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (q_pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/brf_back.sv =====
// Back end: owns the pointers, the byte store and the result register.
// Instantiates brf_ram and brf_modu; uses brf_pkg and the assertion macros.
`default_nettype none
`include "byte_ring_fifo_top_assert.svh"

module brf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [brf_pkg::USIZE_W-1:0]   size,
  input  logic                          cfg_clear,
  input  logic                          q_valid,
  input  brf_pkg::item_t                q_item,
  output logic                          q_pop,
  output logic                          m_valid,
  input  logic                          m_ready,
  output brf_pkg::res_t                 m_res
);

  localparam int PTR_W   = brf_pkg::PTR_W;
  localparam int USIZE_W = brf_pkg::USIZE_W;
  localparam int NREAD_W = brf_pkg::NREAD_W;
  localparam int MIN_W   = brf_pkg::MIN_W;
  localparam int BYTE_W  = brf_pkg::BYTE_W;
  localparam int OUT_W   = brf_pkg::OUT_W;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_RDATA = 5'b00010,
    ST_ADV   = 5'b00100,
    ST_HELD  = 5'b01000,
    ST_STAT  = 5'b10000
  } state_t;

  state_t             state, state_next;
  logic [PTR_W-1:0]   wp, wp_next;
  logic [PTR_W-1:0]   rp, rp_next;
  logic [PTR_W-1:0]   held, held_next;
  logic [NREAD_W-1:0] remain, remain_next;
  logic               adv_tail, adv_tail_next;

  logic               out_free;
  logic [PTR_W-1:0]   wp_inc;
  logic [PTR_W-1:0]   rp_inc;
  logic [PTR_W-1:0]   held_calc;
  logic               full;
  logic [MIN_W-1:0]   min_a;
  logic [NREAD_W-1:0] n_read;

  logic               load;
  brf_pkg::res_t      ld_res;

  logic               ram_we;
  logic               ram_re;
  logic [PTR_W-1:0]   ram_raddr;
  logic [BYTE_W-1:0]  ram_rdata;

  logic               mod_start;
  brf_pkg::mod_req_t  mod_req;
  logic               mod_done;
  logic [PTR_W-1:0]   mod_result;

  brf_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (brf_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp),
    .wdata (q_item.wbyte),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  brf_modu u_modu (
    .clk    (clk),
    .rst    (rst),
    .start  (mod_start),
    .req    (mod_req),
    .size   (size),
    .done   (mod_done),
    .result (mod_result)
  );

  always_comb begin
    out_free  = !m_valid || m_ready;
    wp_inc    = (USIZE_W'(wp) + USIZE_W'(1) == size) ? '0 : wp + PTR_W'(1);
    rp_inc    = (USIZE_W'(rp) + USIZE_W'(1) == size) ? '0 : rp + PTR_W'(1);
    held_calc = (wp >= rp) ? PTR_W'(wp - rp)
                           : PTR_W'(size - USIZE_W'(rp - wp));
    full      = (USIZE_W'(held) + USIZE_W'(1) == size);
    // pop count: min(count, held, MAX_READ)
    min_a     = (MIN_W'(q_item.count) < MIN_W'(held)) ? MIN_W'(q_item.count)
                                                      : MIN_W'(held);
    n_read    = (min_a > MIN_W'(brf_pkg::MAX_READ)) ? NREAD_W'(brf_pkg::MAX_READ)
                                                    : NREAD_W'(min_a);
  end

  always_comb begin
    state_next    = state;
    wp_next       = wp;
    rp_next       = rp;
    held_next     = held;
    remain_next   = remain;
    adv_tail_next = adv_tail;
    q_pop         = 1'b0;
    load          = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = rp;
    mod_start     = 1'b0;
    mod_req.base  = wp;
    mod_req.amount = q_item.count;
    ld_res.read_byte  = '0;
    ld_res.byte_valid = 1'b0;
    ld_res.last       = 1'b1;
    ld_res.accepted   = 1'b1;

    unique case (state)
      ST_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            brf_pkg::OP_WRITE: begin
              load            = 1'b1;
              ld_res.accepted = !full;
              if (!full) begin
                ram_we    = 1'b1;
                wp_next   = wp_inc;
                held_next = held + PTR_W'(1);
              end
            end
            brf_pkg::OP_READ: begin
              if (n_read == '0) begin
                load = 1'b1;
              end else begin
                ram_re      = 1'b1;
                remain_next = n_read;
                state_next  = ST_RDATA;
              end
            end
            brf_pkg::OP_ADV_HEAD: begin
              mod_start     = 1'b1;
              mod_req.base  = wp;
              adv_tail_next = 1'b0;
              state_next    = ST_ADV;
            end
            brf_pkg::OP_ADV_TAIL: begin
              mod_start     = 1'b1;
              mod_req.base  = rp;
              adv_tail_next = 1'b1;
              state_next    = ST_ADV;
            end
            brf_pkg::OP_CLEAR: begin
              load      = 1'b1;
              wp_next   = '0;
              rp_next   = '0;
              held_next = '0;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      ST_RDATA: begin
        if (out_free) begin
          load              = 1'b1;
          ld_res.read_byte  = ram_rdata;
          ld_res.byte_valid = 1'b1;
          ld_res.last       = (remain == NREAD_W'(1));
          rp_next           = rp_inc;
          held_next         = held - PTR_W'(1);
          remain_next       = remain - NREAD_W'(1);
          // fetch the following byte while this one goes out
          if (remain != NREAD_W'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = rp_inc;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ADV: begin
        if (mod_done) begin
          if (adv_tail) begin
            rp_next = mod_result;
          end else begin
            wp_next = mod_result;
          end
          state_next = ST_HELD;
        end
      end
      ST_HELD: begin
        held_next  = held_calc;
        state_next = ST_STAT;
      end
      ST_STAT: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    ld_res.readable  = OUT_W'(held_next);
    ld_res.writeable = OUT_W'(size - USIZE_W'(1) - USIZE_W'(held_next));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      wp       <= '0;
      rp       <= '0;
      held     <= '0;
      remain   <= '0;
      adv_tail <= 1'b0;
      m_valid  <= 1'b0;
    end else begin
      state    <= state_next;
      remain   <= remain_next;
      adv_tail <= adv_tail_next;
      if (cfg_clear) begin
        wp   <= '0;
        rp   <= '0;
        held <= '0;
      end else begin
        wp   <= wp_next;
        rp   <= rp_next;
        held <= held_next;
      end
      if (load) begin
        m_valid <= 1'b1;
      end else if (m_ready) begin
        m_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_res <= ld_res;
    end
  end

  `BRF_CHECK(a_held_range, (USIZE_W'(held) < size), "held count reaches ring size")
  `BRF_CHECK(a_ptr_range, ((USIZE_W'(wp) < size) && (USIZE_W'(rp) < size)),
             "pointer outside ring")
  `BRF_IMPLY(a_held_match, (state == ST_IDLE), (held == held_calc),
             "held count disagrees with pointers")
  `BRF_IMPLY(a_read_remain, (state == ST_RDATA), (remain != '0),
             "read burst with nothing left")
  `BRF_IMPLY(a_mod_done, mod_done, (state == ST_ADV), "modulo result with no advance waiting")

endmodule

`default_nettype wire

// ===== rtl/byte_ring_fifo_top.sv =====
// Byte ring FIFO, top level.
// Input words (s_*) carry a command: write one byte, read up to 64 bytes,
// advance the head or tail pointer, or empty the ring. Each command gives one
// or more result words (m_*) with the readable and writeable byte counts.
// An APB port holds ring_size (offset 0), used clamped to 2..4096; writing it
// empties the ring.
// The front queues up to two decoded commands; the back executes them.
// A status word passes through the command queue and the result register; the
// first byte of a read also passes through the RAM read register.
// Throughput: write, reset and unknown commands one per cycle while m_tready
// allows; a read gives one byte per cycle after its RAM read, under the same condition.
// An advance occupies the back end while the bit-serial modulo unit reduces
// the 13-bit count one bit per cycle, and then for the ST_HELD and ST_STAT states.
// Reset empties the ring and sets ring_size to 4096. Byte storage is not
// cleared; there is no clearing pass.
// When m_tready is low the result register holds, the back end waits and
// the two-entry queue fills, after which s_tready drops.
`default_nettype none

module byte_ring_fifo_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // write_byte [7:0], count [20:8], zero [23:21]
  input  logic [brf_pkg::IN_TDATA_W-1:0]    s_tdata,
  // cmd [2:0]
  input  logic [brf_pkg::CMD_W-1:0]         s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // read_byte [7:0], accepted [8], readable [20:9], writeable [32:21], zero [39:33]
  output logic [brf_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // byte_valid [0]
  output logic                              m_tuser,
  output logic                              m_tlast,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [brf_pkg::APB_AW-1:0]        paddr,
  input  logic [brf_pkg::APB_DW-1:0]        pwdata,
  output logic [brf_pkg::APB_DW-1:0]        prdata,
  output logic                              pready
);

  localparam int CFG_W   = brf_pkg::CFG_W;
  localparam int SZ_W    = brf_pkg::SZ_W;
  localparam int USIZE_W = brf_pkg::USIZE_W;
  localparam int APB_DW  = brf_pkg::APB_DW;

  function automatic logic [USIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] raw);
    logic [SZ_W-1:0] r;
    r = SZ_W'(raw);
    if (r < SZ_W'(2)) begin
      r = SZ_W'(2);
    end else if (r > SZ_W'(brf_pkg::DEPTH)) begin
      r = SZ_W'(brf_pkg::DEPTH);
    end
    return USIZE_W'(r);
  endfunction

  logic [CFG_W-1:0]              ring_size;
  logic [USIZE_W-1:0]            size;
  logic [brf_pkg::REG_IDX_W-1:0] reg_idx;
  logic                          cfg_wr;
  logic                          cfg_clear;

  logic           q_valid;
  brf_pkg::item_t q_item;
  logic           q_pop;
  brf_pkg::res_t  m_res;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[brf_pkg::APB_AW-1:2];
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign cfg_clear = cfg_wr && (reg_idx == brf_pkg::REG_RING_SIZE);
  assign prdata    = (reg_idx == brf_pkg::REG_RING_SIZE) ? APB_DW'(ring_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_size <= brf_pkg::CFG_RESET;
      size      <= clamp_size(brf_pkg::CFG_RESET);
    end else if (cfg_clear) begin
      ring_size <= pwdata[CFG_W-1:0];
      size      <= clamp_size(pwdata[CFG_W-1:0]);
    end
  end

  brf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  brf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .size      (size),
    .cfg_clear (cfg_clear),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_res     (m_res)
  );

  assign m_tdata = {
    (brf_pkg::OUT_TDATA_W - brf_pkg::OUT_USED_W)'(0),
    m_res.writeable,
    m_res.readable,
    m_res.accepted,
    m_res.read_byte
  };
  assign m_tuser = m_res.byte_valid;
  assign m_tlast = m_res.last;

endmodule

`default_nettype wire
